FILE: rtl/drsc_pkg.sv
// ----------------------------------------------------------------------------
// Run-state controller package
// Item types, mode encoding and the codes that the run-state controller
// shares between its files.
// ----------------------------------------------------------------------------
package drsc_pkg;

   // Width of the request tag carried through the controller.
   localparam int TagBits = 16;

   // Event codes.
   localparam logic [2:0] OP_COMMAND  = 3'd0;
   localparam logic [2:0] OP_READY    = 3'd1;
   localparam logic [2:0] OP_FAULT    = 3'd2;
   localparam logic [2:0] OP_COMPLETE = 3'd3;
   localparam logic [2:0] OP_CONSUME  = 3'd4;
   localparam logic [2:0] OP_QUERY    = 3'd5;

   // Command actions.
   localparam logic [2:0] ACT_START     = 3'd0;
   localparam logic [2:0] ACT_STOP      = 3'd1;
   localparam logic [2:0] ACT_ESTOP     = 3'd2;
   localparam logic [2:0] ACT_SAFETY    = 3'd3;
   localparam logic [2:0] ACT_INIT      = 3'd4;
   localparam logic [2:0] ACT_STATUS    = 3'd5;

   // Response kinds.
   localparam logic [1:0] KIND_COMMAND  = 2'd0;
   localparam logic [1:0] KIND_RECOVERY = 2'd1;
   localparam logic [1:0] KIND_RESET    = 2'd2;
   localparam logic [1:0] KIND_STATUS   = 2'd3;

   // Result codes.
   localparam logic [1:0] RES_OK   = 2'd0;
   localparam logic [1:0] RES_REJ  = 2'd1;
   localparam logic [1:0] RES_PROC = 2'd2;

   // Error codes.
   localparam logic [2:0] ERR_NONE     = 3'd0;
   localparam logic [2:0] ERR_TARGET   = 3'd1;
   localparam logic [2:0] ERR_STATE    = 3'd2;
   localparam logic [2:0] ERR_NOTREADY = 3'd3;
   localparam logic [2:0] ERR_UNSUP    = 3'd4;

   typedef enum logic [2:0] {
      MODE_STOPPED = 3'd0,
      MODE_RUNNING = 3'd1,
      MODE_ESTOP   = 3'd2,
      MODE_RECOVER = 3'd3,
      MODE_ERROR   = 3'd4
   } mode_type;

   typedef struct packed {
      logic [2:0]         operation;
      logic [2:0]         action;
      logic               target_ok;
      logic [TagBits-1:0] request_tag;
      logic               ready_level;
   } req_item_type;

   typedef struct packed {
      logic [1:0]         response_kind;
      logic [1:0]         result_code;
      logic [2:0]         err_cause;
      logic               flush_work;
      logic               mode_changed;
      logic [2:0]         mode_now;
      logic [TagBits-1:0] reply_tag;
      logic               reset_was_requested;
      logic               operational;
   } rsp_item_type;

endpackage

FILE: rtl/drsc_engine.sv
// ----------------------------------------------------------------------------
// Run-state engine
// Holds the controller state and works out, for the item in the input
// register, the next state and the result item, if there is one.
// ----------------------------------------------------------------------------
module drsc_engine (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  fire,
   input  drsc_pkg::req_item_type item,
   output logic                  has_result,
   output drsc_pkg::rsp_item_type result
);
   import drsc_pkg::*;

   mode_type           mode_ff, mode_in;
   logic               ready_ff, ready_in;
   logic               reset_pend_ff, reset_pend_in;
   logic               rec_pend_ff, rec_pend_in;
   logic [TagBits-1:0] rec_tag_ff, rec_tag_in;

   always_comb begin
      mode_in       = mode_ff;
      ready_in      = ready_ff;
      reset_pend_in = reset_pend_ff;
      rec_pend_in   = rec_pend_ff;
      rec_tag_in    = rec_tag_ff;

      has_result                 = 1'b0;
      result.response_kind       = KIND_COMMAND;
      result.result_code         = RES_OK;
      result.err_cause           = ERR_NONE;
      result.flush_work          = 1'b0;
      result.mode_changed        = 1'b0;
      result.reply_tag           = '0;
      result.reset_was_requested = 1'b0;

      case (item.operation)
         OP_COMMAND: begin
            has_result       = 1'b1;
            result.reply_tag = item.request_tag;
            if (!item.target_ok) begin
               result.result_code = RES_REJ;
               result.err_cause   = ERR_TARGET;
            end else begin
               case (item.action)
                  ACT_START: begin
                     if (mode_ff == MODE_RUNNING) begin
                        result.result_code = RES_OK;
                     end else if (mode_ff != MODE_STOPPED) begin
                        result.result_code = RES_REJ;
                        result.err_cause   = ERR_STATE;
                     end else if (!ready_ff) begin
                        result.result_code = RES_REJ;
                        result.err_cause   = ERR_NOTREADY;
                     end else begin
                        mode_in             = MODE_RUNNING;
                        result.mode_changed = 1'b1;
                     end
                  end
                  ACT_STOP: begin
                     if (mode_ff == MODE_STOPPED) begin
                        result.result_code = RES_OK;
                     end else if (mode_ff != MODE_RUNNING) begin
                        result.result_code = RES_REJ;
                        result.err_cause   = ERR_STATE;
                     end else begin
                        mode_in             = MODE_STOPPED;
                        result.mode_changed = 1'b1;
                     end
                  end
                  ACT_ESTOP: begin
                     result.mode_changed = (mode_ff != MODE_ESTOP);
                     mode_in             = MODE_ESTOP;
                     rec_pend_in         = 1'b0;
                  end
                  ACT_SAFETY: begin
                     if (mode_ff == MODE_STOPPED && ready_ff) begin
                        result.result_code = RES_OK;
                     end else if (mode_ff == MODE_RECOVER) begin
                        result.flush_work = 1'b1;
                        if (ready_ff) begin
                           mode_in             = MODE_STOPPED;
                           result.mode_changed = 1'b1;
                           rec_pend_in         = 1'b0;
                        end else begin
                           result.result_code = RES_PROC;
                           rec_pend_in        = 1'b1;
                           rec_tag_in         = item.request_tag;
                           reset_pend_in      = 1'b1;
                        end
                     end else if (mode_ff != MODE_ESTOP && mode_ff != MODE_ERROR) begin
                        result.result_code = RES_REJ;
                        result.err_cause   = ERR_STATE;
                     end else begin
                        // Entering recovery drops readiness until the device reports again.
                        mode_in             = MODE_RECOVER;
                        result.mode_changed = 1'b1;
                        ready_in            = 1'b0;
                        reset_pend_in       = 1'b1;
                        rec_pend_in         = 1'b1;
                        rec_tag_in          = item.request_tag;
                        result.flush_work   = 1'b1;
                        result.result_code  = RES_PROC;
                     end
                  end
                  ACT_INIT: begin
                     if (mode_ff == MODE_STOPPED) begin
                        result.result_code = RES_OK;
                     end else if (mode_ff == MODE_RECOVER) begin
                        result.result_code = RES_REJ;
                        result.err_cause   = ERR_NOTREADY;
                     end else begin
                        result.result_code = RES_REJ;
                        result.err_cause   = ERR_UNSUP;
                     end
                  end
                  ACT_STATUS: begin
                     result.result_code = RES_OK;
                  end
                  default: begin
                     result.result_code = RES_REJ;
                     result.err_cause   = ERR_UNSUP;
                  end
               endcase
            end
         end
         OP_READY: begin
            ready_in = item.ready_level;
            if (!item.ready_level && (mode_ff == MODE_RUNNING || mode_ff == MODE_STOPPED)) begin
               mode_in = MODE_ERROR;
            end
         end
         OP_FAULT: begin
            if (mode_ff == MODE_RUNNING) begin
               mode_in     = MODE_ERROR;
               rec_pend_in = 1'b0;
            end
         end
         OP_COMPLETE: begin
            if (mode_ff == MODE_RECOVER && ready_ff && rec_pend_ff) begin
               has_result           = 1'b1;
               result.response_kind = KIND_RECOVERY;
               result.reply_tag     = rec_tag_ff;
               result.mode_changed  = 1'b1;
               mode_in              = MODE_STOPPED;
               rec_pend_in          = 1'b0;
            end
         end
         OP_CONSUME: begin
            has_result                 = 1'b1;
            result.response_kind       = KIND_RESET;
            result.reset_was_requested = reset_pend_ff;
            reset_pend_in              = 1'b0;
         end
         OP_QUERY: begin
            has_result           = 1'b1;
            result.response_kind = KIND_STATUS;
         end
         default: begin
            has_result = 1'b0;
         end
      endcase

      result.mode_now    = mode_in;
      result.operational = (mode_in == MODE_RUNNING) && ready_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff       <= MODE_STOPPED;
         ready_ff      <= 1'b0;
         reset_pend_ff <= 1'b0;
         rec_pend_ff   <= 1'b0;
         rec_tag_ff    <= '0;
      end else if (fire) begin
         mode_ff       <= mode_in;
         ready_ff      <= ready_in;
         reset_pend_ff <= reset_pend_in;
         rec_pend_ff   <= rec_pend_in;
         rec_tag_ff    <= rec_tag_in;
      end
   end

endmodule

FILE: rtl/device_run_state_controller_core.sv
// ----------------------------------------------------------------------------
// Device run-state controller
// Five-mode run controller that answers commands, readiness updates,
// faults, recovery checks, reset consumes and status queries.
// ----------------------------------------------------------------------------
// Each accepted item is captured in an input register, evaluated against
// the mode and flags combinationally, and its result item (if any) written
// to an output register; one item is taken per clock unless stalled.
// An item stays in the input register only while it has a result and the
// output register still holds an item that has not been taken; items that
// produce no result (ready updates, faults, idle completion checks and
// unused event codes) never wait. A result is taken from the output register,
// which it reaches after its item has been held in the input register.
module device_run_state_controller_core (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  drsc_pkg::req_item_type req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output drsc_pkg::rsp_item_type rsp_data
);
   import drsc_pkg::*;

   logic         in_valid_ff, in_valid_in;
   req_item_type in_item_ff;
   logic         out_valid_ff, out_valid_in;
   rsp_item_type out_item_ff;

   logic         has_result;
   rsp_item_type result;
   logic         out_free;
   logic         advance;

   drsc_engine u_engine (
      .clock      (clock),
      .reset      (reset),
      .fire       (advance),
      .item       (in_item_ff),
      .has_result (has_result),
      .result     (result)
   );

   assign out_free  = !out_valid_ff || rsp_ready;
   assign advance   = in_valid_ff && (!has_result || out_free);
   assign req_ready = !in_valid_ff || advance;

   assign in_valid_in  = req_ready ? req_valid : in_valid_ff;
   assign out_valid_in = out_free ? (advance && has_result) : out_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_item_ff <= req_data;
      end
      if (out_free && advance && has_result) begin
         out_item_ff <= result;
      end
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_item_ff;

   // A held item must not be lost or changed while the output is blocked.
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !advance |=> in_valid_ff && $stable(in_item_ff))
      else $error("held input item was dropped or changed");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.operational |-> rsp_data.mode_now == MODE_RUNNING)
      else $error("operational reported outside the running mode");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.reset_was_requested |-> rsp_data.response_kind == KIND_RESET)
      else $error("reset request flag on a result that is not a consume");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.result_code == RES_PROC |-> rsp_data.flush_work)
      else $error("processing result without a work flush");

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Run-state controller testbench
// Drives decoded events into the controller with bursty timing on the input
// and a shifting stall pattern on the result side. A scoreboard keeps its own
// copy of the mode and flags, works out the expected result item for every
// accepted event and checks each returned item field by field, in order.
// ----------------------------------------------------------------------------
module tb_top;
   import drsc_pkg::*;

   // Codes that the package leaves unnamed.
   localparam logic [2:0] ACT_COMPONENT   = 3'd6;
   localparam logic [2:0] ACT_UNSUPPORTED = 3'd7;
   localparam logic [2:0] OP_UNUSED_LOW   = 3'd6;
   localparam logic [2:0] OP_UNUSED_HIGH  = 3'd7;

   // Receiver stall styles.
   localparam int RX_ALWAYS   = 0;
   localparam int RX_COIN     = 1;
   localparam int RX_SLUGGISH = 2;
   localparam int RX_PERIODIC = 3;

   localparam int RANDOM_EVENTS = 1750;

   class run_state_scoreboard;
      mode_type           mode;
      logic               ready_flag;
      logic               reset_pending;
      logic               recovery_pending;
      logic [TagBits-1:0] recovery_tag;
      rsp_item_type       pending_replies[$];
      int                 failures;
      int                 checked;
      int                 kind_count[4];
      logic [7:0]         modes_seen;

      function new();
         mode             = MODE_STOPPED;
         ready_flag       = 1'b0;
         reset_pending    = 1'b0;
         recovery_pending = 1'b0;
         recovery_tag     = '0;
         failures         = 0;
         checked          = 0;
         modes_seen       = '0;
         foreach (kind_count[i]) kind_count[i] = 0;
      endfunction

      function void reject(inout rsp_item_type e, input logic [2:0] code);
         e.result_code = RES_REJ;
         e.err_cause   = code;
      endfunction

      // Applies one accepted event to the shadow state and queues the
      // result item it should cause, if any.
      function void predict_event(req_item_type r);
         rsp_item_type e;
         bit           has_result;
         e          = '0;
         has_result = 1'b1;
         case (r.operation)
            OP_COMMAND: begin
               e.response_kind = KIND_COMMAND;
               e.reply_tag     = r.request_tag;
               if (!r.target_ok) begin
                  reject(e, ERR_TARGET);
               end else begin
                  case (r.action)
                     ACT_START: begin
                        if (mode == MODE_STOPPED) begin
                           if (ready_flag) begin
                              mode           = MODE_RUNNING;
                              e.mode_changed = 1'b1;
                           end else begin
                              reject(e, ERR_NOTREADY);
                           end
                        end else if (mode != MODE_RUNNING) begin
                           reject(e, ERR_STATE);
                        end
                     end
                     ACT_STOP: begin
                        if (mode == MODE_RUNNING) begin
                           mode           = MODE_STOPPED;
                           e.mode_changed = 1'b1;
                        end else if (mode != MODE_STOPPED) begin
                           reject(e, ERR_STATE);
                        end
                     end
                     ACT_ESTOP: begin
                        e.mode_changed   = (mode != MODE_ESTOP);
                        mode             = MODE_ESTOP;
                        recovery_pending = 1'b0;
                     end
                     ACT_SAFETY: begin
                        case (mode)
                           MODE_RECOVER: begin
                              e.flush_work = 1'b1;
                              if (ready_flag) begin
                                 mode             = MODE_STOPPED;
                                 e.mode_changed   = 1'b1;
                                 recovery_pending = 1'b0;
                              end else begin
                                 e.result_code    = RES_PROC;
                                 recovery_pending = 1'b1;
                                 recovery_tag     = r.request_tag;
                                 reset_pending    = 1'b1;
                              end
                           end
                           MODE_ESTOP, MODE_ERROR: begin
                              mode             = MODE_RECOVER;
                              e.mode_changed   = 1'b1;
                              ready_flag       = 1'b0;
                              reset_pending    = 1'b1;
                              recovery_pending = 1'b1;
                              recovery_tag     = r.request_tag;
                              e.flush_work     = 1'b1;
                              e.result_code    = RES_PROC;
                           end
                           MODE_STOPPED: begin
                              if (!ready_flag) reject(e, ERR_STATE);
                           end
                           default: begin
                              reject(e, ERR_STATE);
                           end
                        endcase
                     end
                     ACT_INIT: begin
                        if (mode == MODE_RECOVER) begin
                           reject(e, ERR_NOTREADY);
                        end else if (mode != MODE_STOPPED) begin
                           reject(e, ERR_UNSUP);
                        end
                     end
                     ACT_STATUS: begin
                     end
                     default: begin
                        reject(e, ERR_UNSUP);
                     end
                  endcase
               end
            end
            OP_READY: begin
               ready_flag = r.ready_level;
               if (!r.ready_level && (mode == MODE_RUNNING || mode == MODE_STOPPED))
                  mode = MODE_ERROR;
               has_result = 1'b0;
            end
            OP_FAULT: begin
               if (mode == MODE_RUNNING) begin
                  mode             = MODE_ERROR;
                  recovery_pending = 1'b0;
               end
               has_result = 1'b0;
            end
            OP_COMPLETE: begin
               if (mode != MODE_RECOVER || !ready_flag || !recovery_pending) begin
                  has_result = 1'b0;
               end else begin
                  e.response_kind  = KIND_RECOVERY;
                  e.reply_tag      = recovery_tag;
                  mode             = MODE_STOPPED;
                  e.mode_changed   = 1'b1;
                  recovery_pending = 1'b0;
               end
            end
            OP_CONSUME: begin
               e.response_kind       = KIND_RESET;
               e.reset_was_requested = reset_pending;
               reset_pending         = 1'b0;
            end
            OP_QUERY: begin
               e.response_kind = KIND_STATUS;
            end
            default: begin
               has_result = 1'b0;
            end
         endcase
         if (has_result) begin
            e.mode_now    = mode;
            e.operational = (mode == MODE_RUNNING) && ready_flag;
            pending_replies.push_back(e);
         end
      endfunction

      function string describe(rsp_item_type x);
         return $sformatf({"kind=%0d res=%0d err=%0d flush=%0b chg=%0b mode=%0d ",
                           "tag=%h rst=%0b op=%0b"},
                          x.response_kind, x.result_code, x.err_cause, x.flush_work,
                          x.mode_changed, x.mode_now, x.reply_tag,
                          x.reset_was_requested, x.operational);
      endfunction

      function void report(string what, string want, string got);
         failures++;
         if (failures <= 10)
            $display("[%0t] MISMATCH %s\n   expected: %s\n   actual:   %s",
                     $time, what, want, got);
      endfunction

      function void check_response(rsp_item_type got);
         rsp_item_type want;
         string        bad;
         checked++;
         if (pending_replies.size() == 0) begin
            report("result item with nothing expected", "none", describe(got));
            return;
         end
         want = pending_replies.pop_front();
         bad  = "";
         if (got.response_kind !== want.response_kind) bad = {bad, " response_kind"};
         if (got.result_code !== want.result_code) bad = {bad, " result_code"};
         if (got.err_cause !== want.err_cause) bad = {bad, " err_cause"};
         if (got.flush_work !== want.flush_work) bad = {bad, " flush_work"};
         if (got.mode_changed !== want.mode_changed) bad = {bad, " mode_changed"};
         if (got.mode_now !== want.mode_now) bad = {bad, " mode_now"};
         if (got.reply_tag !== want.reply_tag) bad = {bad, " reply_tag"};
         if (got.reset_was_requested !== want.reset_was_requested)
            bad = {bad, " reset_was_requested"};
         if (got.operational !== want.operational) bad = {bad, " operational"};
         if (bad != "") report({"in", bad}, describe(want), describe(got));
         kind_count[want.response_kind]++;
         modes_seen[want.mode_now] = 1'b1;
      endfunction

      function int pending();
         return pending_replies.size();
      endfunction
   endclass

   logic         clock     = 1'b0;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   req_item_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   rsp_item_type rsp_data;

   run_state_scoreboard sb = new();

   int burst_left  = 0;
   int event_count = 0;
   int rx_cycle    = 0;
   int rx_style    = RX_ALWAYS;

   device_run_state_controller_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   always #5 clock = ~clock;

   // Both handshakes are observed here, before the block's own updates land.
   always @(posedge clock) begin
      if (!reset && req_valid && req_ready) sb.predict_event(req_data);
      if (!reset && rsp_valid && rsp_ready) sb.check_response(rsp_data);
   end

   // The receiver switches at random between its stall habits.
   always @(negedge clock) begin
      rx_cycle <= rx_cycle + 1;
      if (rx_cycle % 256 == 0) rx_style <= $urandom_range(RX_ALWAYS, RX_PERIODIC);
      case (rx_style)
         RX_ALWAYS:   rsp_ready <= 1'b1;
         RX_COIN:     rsp_ready <= 1'($urandom_range(0, 1));
         RX_SLUGGISH: rsp_ready <= ($urandom_range(0, 3) == 0);
         default:     rsp_ready <= (rx_cycle % 8) < 4;
      endcase
   end

   function automatic req_item_type make_item(logic [2:0] op, logic [2:0] act, logic tgt,
                                              logic [TagBits-1:0] tag, logic lvl);
      req_item_type r;
      r.operation   = op;
      r.action      = act;
      r.target_ok   = tgt;
      r.request_tag = tag;
      r.ready_level = lvl;
      return r;
   endfunction

   function automatic req_item_type random_item();
      int         p;
      logic [2:0] op;
      p = $urandom_range(0, 99);
      if (p < 45)      op = OP_COMMAND;
      else if (p < 60) op = OP_READY;
      else if (p < 68) op = OP_FAULT;
      else if (p < 80) op = OP_COMPLETE;
      else if (p < 88) op = OP_CONSUME;
      else if (p < 95) op = OP_QUERY;
      else             op = $urandom_range(0, 1) ? OP_UNUSED_HIGH : OP_UNUSED_LOW;
      return make_item(op, 3'($urandom_range(0, 7)), $urandom_range(0, 9) != 0,
                       TagBits'($urandom), $urandom_range(0, 3) != 0);
   endfunction

   task automatic idle_sender(input int cycles);
      @(negedge clock);
      req_valid <= 1'b0;
      req_data  <= $bits(req_item_type)'($urandom);
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic send_item(input req_item_type item);
      if (burst_left == 0) begin
         if ($urandom_range(0, 3) != 0) idle_sender($urandom_range(1, 6));
         burst_left = ($urandom_range(0, 9) == 0) ? 150 : $urandom_range(1, 20);
      end
      burst_left--;
      @(negedge clock);
      req_valid <= 1'b1;
      req_data  <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (item.operation <= OP_QUERY) event_count++;
   endtask

   task automatic send_command(input logic [2:0] act);
      send_item(make_item(OP_COMMAND, act, 1'b1, TagBits'($urandom),
                          $urandom_range(0, 1) != 0));
   endtask

   task automatic wait_for_drain();
      idle_sender(1);
      while (sb.pending() != 0) @(posedge clock);
   endtask

   // A well-formed trip into recovery and back, with random tags and detours.
   task automatic run_recovery_scenario();
      int extra;
      case ($urandom_range(0, 2))
         0: send_command(ACT_ESTOP);
         1: begin
            send_item(make_item(OP_READY, ACT_START, 1'b1, TagBits'($urandom), 1'b1));
            send_command(ACT_START);
            send_item(make_item(OP_FAULT, 3'($urandom_range(0, 7)), 1'b1,
                                TagBits'($urandom), 1'b0));
         end
         default: send_item(make_item(OP_READY, ACT_STOP, 1'b0, TagBits'($urandom), 1'b0));
      endcase
      if ($urandom_range(0, 3) == 0)
         send_item(make_item(OP_COMPLETE, ACT_START, 1'b1, TagBits'($urandom), 1'b1));
      send_command(ACT_SAFETY);
      extra = $urandom_range(0, 2);
      repeat (extra) begin
         case ($urandom_range(0, 2))
            0:       send_command(ACT_SAFETY);
            1:       send_item(make_item(OP_QUERY, ACT_STATUS, 1'b1, TagBits'($urandom), 1'b1));
            default: send_command(ACT_INIT);
         endcase
      end
      if ($urandom_range(0, 6) != 0)
         send_item(make_item(OP_READY, ACT_START, 1'b1, TagBits'($urandom), 1'b1));
      if ($urandom_range(0, 1))
         send_item(make_item(OP_COMPLETE, ACT_STOP, 1'b0, TagBits'($urandom), 1'b0));
      else
         send_command(ACT_SAFETY);
      send_item(make_item(OP_CONSUME, ACT_ESTOP, 1'b1, TagBits'($urandom), 1'b1));
   endtask

   initial begin
      int  target;
      bit  drained_mid;
      drained_mid = 1'b0;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed walk through every mode, action and corner case.
      send_item(make_item(OP_QUERY, ACT_START, 1'b1, 16'hFFFF, 1'b1));
      send_item(make_item(OP_COMMAND, ACT_START, 1'b1, 16'h0000, 1'b0));
      send_item(make_item(OP_READY, ACT_START, 1'b0, 16'h1234, 1'b1));
      send_item(make_item(OP_COMMAND, ACT_START, 1'b0, 16'hFFFF, 1'b1));
      send_item(make_item(OP_COMMAND, ACT_START, 1'b1, 16'h0001, 1'b0));
      send_item(make_item(OP_COMMAND, ACT_START, 1'b1, 16'h8000, 1'b0));
      send_item(make_item(OP_COMMAND, ACT_INIT, 1'b1, 16'h00FF, 1'b0));
      send_item(make_item(OP_COMMAND, ACT_STATUS, 1'b1, 16'hFF00, 1'b0));
      send_item(make_item(OP_COMMAND, ACT_COMPONENT, 1'b1, 16'h5555, 1'b0));
      send_item(make_item(OP_COMMAND, ACT_UNSUPPORTED, 1'b1, 16'hAAAA, 1'b1));
      send_item(make_item(OP_COMMAND, ACT_SAFETY, 1'b1, 16'h0F0F, 1'b0));
      send_item(make_item(OP_FAULT, ACT_START, 1'b1, 16'h0000, 1'b0));
      send_item(make_item(OP_COMMAND, ACT_STOP, 1'b1, 16'hF0F0, 1'b0));
      send_item(make_item(OP_COMMAND, ACT_SAFETY, 1'b1, 16'hBEEF, 1'b0));
      send_item(make_item(OP_COMMAND, ACT_INIT, 1'b1, 16'h0002, 1'b0));
      send_item(make_item(OP_COMPLETE, ACT_START, 1'b1, 16'h0003, 1'b0));
      send_item(make_item(OP_COMMAND, ACT_SAFETY, 1'b1, 16'hCAFE, 1'b0));
      send_item(make_item(OP_READY, ACT_START, 1'b1, 16'h0000, 1'b1));
      send_item(make_item(OP_COMPLETE, ACT_START, 1'b1, 16'hFFFF, 1'b0));
      send_item(make_item(OP_CONSUME, ACT_START, 1'b1, 16'hFFFF, 1'b0));
      send_item(make_item(OP_CONSUME, ACT_START, 1'b1, 16'h0000, 1'b0));
      send_item(make_item(OP_COMMAND, ACT_ESTOP, 1'b1, 16'h1111, 1'b0));
      send_item(make_item(OP_COMMAND, ACT_ESTOP, 1'b1, 16'h2222, 1'b0));
      send_item(make_item(OP_UNUSED_LOW, ACT_UNSUPPORTED, 1'b1, 16'hFFFF, 1'b1));
      send_item(make_item(OP_UNUSED_HIGH, ACT_START, 1'b0, 16'h0000, 1'b0));
      send_item(make_item(OP_COMMAND, ACT_SAFETY, 1'b1, 16'h3333, 1'b0));
      send_item(make_item(OP_READY, ACT_START, 1'b1, 16'h0000, 1'b1));
      send_item(make_item(OP_COMMAND, ACT_SAFETY, 1'b1, 16'h4444, 1'b0));
      send_item(make_item(OP_COMMAND, ACT_STOP, 1'b1, 16'h7FFF, 1'b0));
      send_item(make_item(OP_READY, ACT_START, 1'b1, 16'h0000, 1'b0));
      wait_for_drain();

      target = event_count + RANDOM_EVENTS;
      while (event_count < target) begin
         if (!drained_mid && event_count >= target - RANDOM_EVENTS / 2) begin
            wait_for_drain();
            drained_mid = 1'b1;
         end
         if ($urandom_range(0, 3) == 0) run_recovery_scenario();
         else send_item(random_item());
      end

      wait_for_drain();
      repeat (10) @(posedge clock);

      $display("Run covered %0d events and %0d result items: %0d command, %0d recovery,",
               event_count, sb.checked, sb.kind_count[KIND_COMMAND],
               sb.kind_count[KIND_RECOVERY]);
      $display("%0d reset-consume and %0d status results; modes reported (bit per mode): %b",
               sb.kind_count[KIND_RESET], sb.kind_count[KIND_STATUS], sb.modes_seen[4:0]);
      if (sb.failures == 0 && sb.pending() == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("%0d failures, %0d expected items outstanding", sb.failures, sb.pending());
         $display("FAILED: results differ");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Timed out with %0d expected items outstanding", sb.pending());
      $display("FAILED: results differ");
      $finish;
   end

endmodule
